### rtl/dedupq_pkg.sv
package dedupq_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int TICK_W = 32;
    localparam int ID_W   = 31;
    localparam int CMD_W  = 3;

    localparam logic [ID_W-1:0] ID_MAX = 31'h7fff_ffff;

    // Command codes carried in the low bits of the input tuser.
    localparam logic [CMD_W-1:0] CMD_CAPTURE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FORGET  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ACK     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    // Stream widths: input tdata is key, data, tick, publish padded to bytes.
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic             start;
        logic             forget;
        logic             clear_all;
        logic [KEY_W-1:0] key;
    } t_key_req;

    typedef struct packed {
        logic done;
        logic stored;
    } t_key_rsp;

endpackage

### rtl/dedupq_ram.sv
module dedupq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dedupq_keys.sv
module dedupq_keys #(
    parameter int SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dedupq_pkg::t_key_req i_req,
    output dedupq_pkg::t_key_rsp o_rsp
);

    import dedupq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] r_valid;
    logic             r_busy;
    logic             r_forget;
    logic [KEY_W-1:0] r_key;
    logic [CW-1:0]    r_rd_idx;
    logic             r_cmp_vld;
    logic [IW-1:0]    r_cmp_idx;
    logic             r_dup;
    logic             r_free_found;
    logic [IW-1:0]    r_free_idx;
    logic             r_done;
    logic             r_stored;

    logic             rd_more;
    logic             scan_end;
    logic             hit;
    logic             slot_free;
    logic             do_store;
    logic [KEY_W-1:0] rdata;

    assign rd_more   = r_rd_idx < CW'(SLOTS);
    assign scan_end  = r_busy && !rd_more && !r_cmp_vld;
    assign hit       = r_cmp_vld && r_valid[r_cmp_idx] && (rdata == r_key);
    assign slot_free = r_cmp_vld && !r_valid[r_cmp_idx];
    assign do_store  = scan_end && !r_forget && !r_dup && r_free_found;

    dedupq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(SLOTS)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (do_store),
        .i_waddr(r_free_idx),
        .i_wdata(r_key),
        .i_re   (r_busy && rd_more),
        .i_raddr(r_rd_idx[IW-1:0]),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_busy    <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
            r_stored  <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_stored <= 1'b0;
            if (i_req.clear_all) begin
                r_valid <= '0;
            end else if (i_req.start) begin
                r_busy       <= 1'b1;
                r_forget     <= i_req.forget;
                r_key        <= i_req.key;
                r_rd_idx     <= '0;
                r_cmp_vld    <= 1'b0;
                r_dup        <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_busy) begin
                // The compare works on the address issued in the cycle before.
                r_cmp_vld <= rd_more;
                r_cmp_idx <= r_rd_idx[IW-1:0];
                if (rd_more) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (hit) begin
                    r_dup <= 1'b1;
                    if (r_forget) begin
                        r_valid[r_cmp_idx] <= 1'b0;
                    end
                end
                if (slot_free && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
                if (scan_end) begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_stored <= do_store;
                    if (do_store) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.stored = r_stored;

endmodule

### rtl/dedup_event_queue_with_ttl_unit.sv
// Deduplicating event queue with a time-to-live. Each input item is one
// command: capture, forget key, ack head, peek, reset or clear queue, and
// each command returns exactly one result item. Captures register a nonzero
// source key once in a key table and, when publish is set and the ring has
// room, enqueue the payload with a fresh id (1 up to 0x7fffffff, then back
// to 1) and the capture tick. Peek drops head events older than ttl_ticks
// (age taken modulo 2^32) and reports the surviving head. The block takes
// one item at a time. Capture and forget walk the key table through its
// single read port, while a capture with a zero key or a missing payload
// is rejected without a walk. Peek fetches each head entry from the ring
// memory before its age is checked, and discards expired head events one
// by one until it finds a live head or the queue is empty. A new item is
// taken while the previous result still sits in the output register. The
// ttl register may be written at any cycle the block is idle and is always ready.
module dedup_event_queue_with_ttl_unit #(
    parameter int SLOTS     = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration: ttl_ticks.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dedupq_pkg::TICK_W-1:0]    i_cfg_data,
    // Command stream in.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // source_key[31:0], event_data[63:32], now_tick[95:64], publish[96]
    input  logic [dedupq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[2:0], payload_present[3]
    input  logic [dedupq_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // Result stream out.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // head_data[31:0], head_id[62:32]
    output logic [dedupq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // accepted[0], head_valid[1]
    output logic [dedupq_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    import dedupq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
    localparam int RW = SW + ID_W + TICK_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_KEYS     = 3'd1;
    localparam logic [2:0] S_PEEK     = 3'd2;
    localparam logic [2:0] S_PEEK_CHK = 3'd3;
    localparam logic [2:0] S_OUT      = 3'd4;

    logic [2:0]        r_state;
    logic [TICK_W-1:0] r_ttl;

    // Latched command item.
    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_data;
    logic [TICK_W-1:0] r_tick;
    logic              r_publish;

    // Queue bookkeeping.
    logic [IW-1:0]     r_head;
    logic [CW-1:0]     r_count;
    logic [ID_W-1:0]   r_last_id;

    // Result being built, and the output register.
    logic              r_res_acc;
    logic              r_res_hvalid;
    logic [DATA_W-1:0] r_res_hdata;
    logic [ID_W-1:0]   r_res_hid;
    logic              r_m_valid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [M_TUSER_W-1:0] r_m_tuser;

    logic              r_key_start;
    logic              r_key_forget;
    logic              r_key_clear;

    t_key_req          key_req;
    t_key_rsp          key_rsp;

    logic              in_acc;
    logic [CMD_W-1:0]  in_cmd;
    logic [KEY_W-1:0]  in_key;
    logic              in_present;
    logic [IW-1:0]     n_head;
    logic [CW:0]       tail_sum;
    logic [IW-1:0]     tail;
    logic [ID_W-1:0]   n_id;
    logic              ring_we;
    logic              ring_re;
    logic [RW-1:0]     ring_wdata;
    logic [RW-1:0]     ring_rdata;
    logic [TICK_W-1:0] age;
    logic              out_free;

    assign in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd     = i_s_axis_tuser[CMD_W-1:0];
    assign in_present = i_s_axis_tuser[CMD_W];
    assign in_key     = i_s_axis_tdata[KEY_W-1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;

    // Ring pointer arithmetic; head plus count stays below twice the depth.
    assign n_head   = (r_head == IW'(SLOTS - 1)) ? '0 : r_head + IW'(1);
    assign tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    always_comb begin
        if (tail_sum >= (CW + 1)'(SLOTS)) begin
            tail = IW'(tail_sum - (CW + 1)'(SLOTS));
        end else begin
            tail = IW'(tail_sum);
        end
    end
    assign n_id = (r_last_id >= ID_MAX) ? ID_W'(1) : r_last_id + ID_W'(1);

    assign ring_we = (r_state == S_KEYS) && key_rsp.done && (r_cmd == CMD_CAPTURE)
                     && key_rsp.stored && r_publish && (r_count < CW'(SLOTS));
    assign ring_re = (r_state == S_PEEK) && (r_count != '0);
    assign ring_wdata = {r_tick, n_id, r_data[SW-1:0]};

    dedupq_ram #(
        .WIDTH(RW),
        .DEPTH(SLOTS)
    ) u_ring_ram (
        .i_clk  (i_clk),
        .i_we   (ring_we),
        .i_waddr(tail),
        .i_wdata(ring_wdata),
        .i_re   (ring_re),
        .i_raddr(r_head),
        .o_rdata(ring_rdata)
    );

    // Modular age of the fetched head entry.
    assign age = r_tick - ring_rdata[RW-1 -: TICK_W];

    assign key_req.start     = r_key_start;
    assign key_req.forget    = r_key_forget;
    assign key_req.clear_all = r_key_clear;
    assign key_req.key       = r_key;

    dedupq_keys #(
        .SLOTS(SLOTS)
    ) u_keys (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (key_req),
        .o_rsp  (key_rsp)
    );

    assign out_free = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ttl        <= TICK_W'(64);
            r_head       <= '0;
            r_count      <= '0;
            r_last_id    <= '0;
            r_m_valid    <= 1'b0;
            r_key_start  <= 1'b0;
            r_key_clear  <= 1'b0;
            r_key_forget <= 1'b0;
        end else begin
            r_key_start <= 1'b0;
            r_key_clear <= 1'b0;
            if (i_cfg_valid) begin
                r_ttl <= i_cfg_data;
            end
            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd        <= in_cmd;
                        r_key        <= in_key;
                        r_data       <= i_s_axis_tdata[KEY_W +: DATA_W];
                        r_tick       <= i_s_axis_tdata[KEY_W + DATA_W +: TICK_W];
                        r_publish    <= i_s_axis_tdata[KEY_W + DATA_W + TICK_W];
                        r_res_acc    <= 1'b0;
                        r_res_hvalid <= 1'b0;
                        r_res_hdata  <= '0;
                        r_res_hid    <= '0;
                        r_state      <= S_OUT;
                        case (in_cmd)
                            CMD_CAPTURE: begin
                                // Zero key or missing payload is rejected at once.
                                if (in_key != '0 && in_present) begin
                                    r_key_start  <= 1'b1;
                                    r_key_forget <= 1'b0;
                                    r_state      <= S_KEYS;
                                end
                            end
                            CMD_FORGET: begin
                                r_key_start  <= 1'b1;
                                r_key_forget <= 1'b1;
                                r_state      <= S_KEYS;
                            end
                            CMD_ACK: begin
                                if (r_count != '0) begin
                                    r_head  <= n_head;
                                    r_count <= r_count - CW'(1);
                                end
                            end
                            CMD_PEEK: begin
                                r_state <= S_PEEK;
                            end
                            CMD_RESET: begin
                                r_key_clear <= 1'b1;
                                r_head      <= '0;
                                r_count     <= '0;
                            end
                            CMD_CLEAR: begin
                                r_head  <= '0;
                                r_count <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_KEYS: begin
                    if (key_rsp.done) begin
                        if (ring_we) begin
                            r_last_id <= n_id;
                            r_count   <= r_count + CW'(1);
                            r_res_acc <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_PEEK: begin
                    // Empty queue ends the peek with an all-zero result.
                    if (r_count == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PEEK_CHK;
                    end
                end
                S_PEEK_CHK: begin
                    if (age <= r_ttl) begin
                        r_res_hvalid <= 1'b1;
                        r_res_hdata  <= DATA_W'(ring_rdata[SW-1:0]);
                        r_res_hid    <= ring_rdata[SW +: ID_W];
                        r_state      <= S_OUT;
                    end else begin
                        r_head  <= n_head;
                        r_count <= r_count - CW'(1);
                        r_state <= S_PEEK;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_tdata <= {1'b0, r_res_hid, r_res_hdata};
                        r_m_tuser <= {r_res_hvalid, r_res_acc};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dedupq_pkg::*;

    localparam int SLOTS         = 16;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 24;      // a capture walks all slots
    localparam int QUIET_LIMIT   = 5000;    // cycles with no handshake at all
    localparam int PHASE_ITEMS   = 150;
    localparam int KEY_POOL      = 28;
    localparam int REPORT_LIMIT  = 40;
    localparam logic [TICK_W-1:0] DEFAULT_TTL = 32'd64;

    // The block ignores the two spare command codes.
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic              present;
        logic [DATA_W-1:0] data;
        logic [TICK_W-1:0] tick;
        logic              publish;
    } t_cmd_item;

    typedef struct {
        logic              accepted;
        logic              head_valid;
        logic [DATA_W-1:0] head_data;
        logic [ID_W-1:0]   head_id;
    } t_queue_result;

    // Clock, reset and every block input start at known values.
    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [TICK_W-1:0]    cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_ready   = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [M_TUSER_W-1:0] o_m_axis_tuser;

    // Shadow copy of the queue state, updated as each item is accepted.
    logic [KEY_W-1:0]  pm_keys      [SLOTS];
    logic [DATA_W-1:0] pm_ring_data [SLOTS];
    logic [ID_W-1:0]   pm_ring_id   [SLOTS];
    logic [TICK_W-1:0] pm_ring_tick [SLOTS];
    int                pm_head;
    int                pm_count;
    logic [ID_W-1:0]   pm_last_id;
    logic [TICK_W-1:0] pm_ttl;

    t_queue_result     expected_results [$];

    // Stimulus knobs shared between the test tasks and the result-side process.
    int                tx_gap_pct;
    int                rx_stall_pct;
    int                rx_hold_request;
    logic [TICK_W-1:0] cur_tick;
    logic [KEY_W-1:0]  last_captured_key;

    int error_count;
    int n_items;
    int n_results;
    int n_enqueued;
    int n_live_heads;
    int n_expired;
    int n_dup_rejects;
    int n_table_full;
    int n_ring_full;
    int n_ttl_writes;
    int quiet_cycles = 0;

    dedup_event_queue_with_ttl_unit #(
        .SLOTS    (SLOTS),
        .DATA_BITS(DATA_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Works out the result of one command and advances the shadow state. The
    // key table is scanned in full, so a duplicate anywhere rejects the capture
    // even when a free slot comes earlier.
    function automatic t_queue_result predict_queue_result(t_cmd_item it);
        t_queue_result     res;
        int                open_slot;
        int                tail;
        bit                known;
        logic [TICK_W-1:0] age;
        res = '{default: '0};
        case (it.cmd)
            CMD_CAPTURE: begin
                if (it.key != '0 && it.present) begin
                    open_slot = -1;
                    known     = 1'b0;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (pm_keys[s] == it.key) known = 1'b1;
                        if (pm_keys[s] == '0 && open_slot < 0) open_slot = s;
                    end
                    if (known) begin
                        n_dup_rejects++;
                    end else if (open_slot < 0) begin
                        n_table_full++;
                    end else begin
                        // The key stays registered even when nothing is queued.
                        pm_keys[open_slot] = it.key;
                        if (it.publish && pm_count >= SLOTS) begin
                            n_ring_full++;
                        end else if (it.publish) begin
                            pm_last_id = (pm_last_id == ID_MAX) ? ID_W'(1) : pm_last_id + 1'b1;
                            tail = (pm_head + pm_count) % SLOTS;
                            pm_ring_data[tail] = it.data;
                            pm_ring_id[tail]   = pm_last_id;
                            pm_ring_tick[tail] = it.tick;
                            pm_count++;
                            res.accepted = 1'b1;
                            n_enqueued++;
                        end
                    end
                end
            end
            CMD_FORGET: begin
                // A zero key only matches free slots, which changes nothing.
                for (int s = 0; s < SLOTS; s++)
                    if (pm_keys[s] == it.key) pm_keys[s] = '0;
            end
            CMD_ACK: begin
                if (pm_count != 0) begin
                    pm_head = (pm_head + 1) % SLOTS;
                    pm_count--;
                end
            end
            CMD_PEEK: begin
                // Ages are taken modulo 2^32, so a tick that wrapped still counts forward.
                while (pm_count != 0 && !res.head_valid) begin
                    age = it.tick - pm_ring_tick[pm_head];
                    if (age <= pm_ttl) begin
                        res.head_valid = 1'b1;
                        res.head_data  = pm_ring_data[pm_head];
                        res.head_id    = pm_ring_id[pm_head];
                        n_live_heads++;
                    end else begin
                        pm_head = (pm_head + 1) % SLOTS;
                        pm_count--;
                        n_expired++;
                    end
                end
            end
            CMD_RESET: begin
                // The id counter survives a reset command.
                foreach (pm_keys[s]) pm_keys[s] = '0;
                pm_head  = 0;
                pm_count = 0;
            end
            CMD_CLEAR: begin
                pm_head  = 0;
                pm_count = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_cmd_item make_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                           logic present, logic [DATA_W-1:0] data,
                                           logic [TICK_W-1:0] tick, logic publish);
        t_cmd_item it;
        it.cmd     = cmd;
        it.key     = key;
        it.present = present;
        it.data    = data;
        it.tick    = tick;
        it.publish = publish;
        return it;
    endfunction

    // No gap outside the given percentage; inside it mostly a short one, now and then a long one.
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(12, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 35;
            default: return 70;
        endcase
    endfunction

    // A small pool of keys makes duplicates and forgets hit; full-width keys
    // and the zero key show up now and then.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return '0;
        if (roll < 15) return KEY_W'($urandom);
        return KEY_W'($urandom_range(1, KEY_POOL));
    endfunction

    // In a fill burst most captures are followed by a forget of the same key,
    // so the key table stays open while the event ring fills to the top.
    function automatic t_cmd_item random_command(bit fill_burst);
        t_cmd_item it;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) cur_tick += TICK_W'($urandom_range(0, 2));
        else if (roll < 95) cur_tick += TICK_W'($urandom_range(3, 40));
        else cur_tick += TICK_W'($urandom_range(41, 400));
        it.key     = pick_key();
        it.present = ($urandom_range(0, 19) != 0);
        it.data    = DATA_W'($urandom);
        it.tick    = ($urandom_range(0, 24) == 0) ? TICK_W'($urandom) : cur_tick;
        it.publish = ($urandom_range(0, 9) != 0);
        roll = $urandom_range(0, 99);
        if (fill_burst) begin
            if (roll < 55) begin
                it.cmd = CMD_CAPTURE;
            end else if (roll < 85) begin
                it.cmd = CMD_FORGET;
                it.key = last_captured_key;
            end else if (roll < 93) begin
                it.cmd = CMD_PEEK;
            end else begin
                it.cmd = CMD_ACK;
            end
        end else begin
            if (roll < 35) it.cmd = CMD_CAPTURE;
            else if (roll < 47) it.cmd = CMD_FORGET;
            else if (roll < 62) it.cmd = CMD_ACK;
            else if (roll < 90) it.cmd = CMD_PEEK;
            else if (roll < 93) it.cmd = CMD_RESET;
            else if (roll < 97) it.cmd = CMD_CLEAR;
            else it.cmd = roll[0] ? CMD_RSVD7 : CMD_RSVD6;
        end
        if (it.cmd == CMD_CAPTURE) last_captured_key = it.key;
        // Some peeks land exactly on the ttl edge of the current head.
        if (it.cmd == CMD_PEEK && pm_count != 0 && $urandom_range(0, 7) == 0)
            it.tick = pm_ring_tick[pm_head] + pm_ttl + TICK_W'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < REPORT_LIMIT)
            $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
                     $time, n_results, what, got, want);
        error_count++;
    endtask

    // Offers one item after a random gap and records its expected result once
    // the block takes it. Valid is left high so back-to-back items need no
    // second assignment in the same step; the next gap or a drain lowers it.
    task automatic send_item(t_cmd_item it);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= S_TDATA_W'({it.publish, it.tick, it.data, it.key});
        s_tuser <= {it.present, it.cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_results.push_back(predict_queue_result(it));
        n_items++;
    endtask

    // Stops offering items and waits until every result has come back, then
    // lets the block finish whatever walk it may still be on.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ttl(logic [TICK_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        pm_ttl = value;
        n_ttl_writes++;
    endtask

    task automatic check_result();
        t_queue_result got;
        t_queue_result want;
        got.accepted   = o_m_axis_tuser[0];
        got.head_valid = o_m_axis_tuser[1];
        got.head_data  = o_m_axis_tdata[DATA_W-1:0];
        got.head_id    = o_m_axis_tdata[DATA_W +: ID_W];
        n_results++;
        if (expected_results.size() == 0) begin
            report_mismatch("arrived with nothing pending", o_m_axis_tdata, '0);
            return;
        end
        want = expected_results.pop_front();
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
        if (got.head_valid !== want.head_valid)
            report_mismatch("head_valid", got.head_valid, want.head_valid);
        if (got.head_data !== want.head_data)
            report_mismatch("head_data", got.head_data, want.head_data);
        if (got.head_id !== want.head_id)
            report_mismatch("head_id", got.head_id, want.head_id);
    endtask

    // Result side: samples each handshake at the edge where it happens, then
    // decides ready for the next cycle. A hold request from a test forces a
    // long stretch of not-ready that this process counts down itself.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && m_ready) check_result();
            if (rx_hold_request > 0) begin
                stall_left      = rx_hold_request;
                rx_hold_request = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap(rx_stall_pct);
                m_ready <= (stall_left == 0);
            end
        end
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("dedup_event_queue_with_ttl_unit: mismatch");
            $finish;
        end
    end

    // Hand-picked items at the reset ttl of 64: rejections for a zero key,
    // a missing payload and duplicates, a key stored without publishing, the
    // ttl edge from both sides, a tick that wraps, ack and peek on an empty
    // queue, the spare codes, clear keeping keys and reset keeping the id counter.
    task automatic test_directed_cases();
        tx_gap_pct   = 30;
        rx_stall_pct = 30;
        send_item(make_cmd(CMD_PEEK,    '0,           1'b0, '0,           32'd100, 1'b0));
        send_item(make_cmd(CMD_ACK,     '0,           1'b0, '0,           32'd100, 1'b0));
        send_item(make_cmd(CMD_CAPTURE, '0,           1'b1, 32'h1234_5678, 32'd100, 1'b1));
        send_item(make_cmd(CMD_CAPTURE, 32'd5,        1'b0, 32'h1234_5678, 32'd100, 1'b1));
        send_item(make_cmd(CMD_CAPTURE, '1,           1'b1, '1,           32'd100, 1'b1));
        send_item(make_cmd(CMD_CAPTURE, '1,           1'b1, 32'h0000_0001, 32'd101, 1'b1));
        send_item(make_cmd(CMD_CAPTURE, 32'd7,        1'b1, '0,           32'd102, 1'b0));
        send_item(make_cmd(CMD_CAPTURE, 32'd7,        1'b1, 32'h5555_5555, 32'd103, 1'b1));
        send_item(make_cmd(CMD_FORGET,  '0,           1'b0, '0,           32'd104, 1'b0));
        send_item(make_cmd(CMD_PEEK,    '0,           1'b0, '0,           32'd164, 1'b0));
        send_item(make_cmd(CMD_PEEK,    '0,           1'b0, '0,           32'd165, 1'b0));
        send_item(make_cmd(CMD_FORGET,  32'd7,        1'b0, '0,           32'd165, 1'b0));
        send_item(make_cmd(CMD_CAPTURE, 32'd7,        1'b1, '0,           32'hFFFF_FFF0, 1'b1));
        send_item(make_cmd(CMD_PEEK,    '0,           1'b0, '0,           32'h0000_0030, 1'b0));
        send_item(make_cmd(CMD_CAPTURE, 32'd9,        1'b1, 32'hA5A5_5A5A, 32'h0000_0030, 1'b1));
        send_item(make_cmd(CMD_ACK,     '0,           1'b0, '0,           32'h0000_0030, 1'b0));
        send_item(make_cmd(CMD_PEEK,    '0,           1'b0, '0,           32'h0000_0030, 1'b0));
        send_item(make_cmd(CMD_RSVD6,   '1,           1'b1, '1,           '1,       1'b1));
        send_item(make_cmd(CMD_RSVD7,   '1,           1'b1, '1,           '1,       1'b1));
        send_item(make_cmd(CMD_CLEAR,   '0,           1'b0, '0,           32'h0000_0031, 1'b0));
        send_item(make_cmd(CMD_PEEK,    '0,           1'b0, '0,           32'h0000_0031, 1'b0));
        send_item(make_cmd(CMD_CAPTURE, 32'd9,        1'b1, 32'h0F0F_F0F0, 32'h0000_0032, 1'b1));
        send_item(make_cmd(CMD_RESET,   '0,           1'b0, '0,           32'h0000_0032, 1'b0));
        send_item(make_cmd(CMD_CAPTURE, 32'd9,        1'b1, 32'h8000_0000, '0,       1'b1));
        send_item(make_cmd(CMD_PEEK,    '0,           1'b0, '0,           '0,       1'b0));
        wait_results_drained();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the block fills its output and stops taking input; then the sender
    // pauses until every result is back before starting again.
    task automatic test_output_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        rx_hold_request = 300;
        repeat (30) send_item(random_command(1'b0));
        wait_results_drained();
        repeat (12) send_item(random_command(1'b1));
        wait_results_drained();
    endtask

    // One phase per ttl setting, the extremes among them. Each phase is cut
    // into short episodes with their own idling on both sides and their own
    // mix of plain traffic or ring-filling bursts.
    task automatic test_ttl_phases();
        logic [TICK_W-1:0] ttl_list [5];
        int                done;
        int                episode_len;
        bit                fill;
        ttl_list[0] = '0;
        ttl_list[1] = '1;
        ttl_list[2] = TICK_W'($urandom_range(1, 200));
        ttl_list[3] = TICK_W'($urandom);
        ttl_list[4] = DEFAULT_TTL;
        foreach (ttl_list[p]) begin
            write_ttl(ttl_list[p]);
            // Run one phase right across the wrap of the tick counter.
            if (p == 2) cur_tick = 32'hFFFF_FF00;
            done = 0;
            while (done < PHASE_ITEMS) begin
                episode_len  = $urandom_range(8, 24);
                fill         = ($urandom_range(0, 2) == 0);
                tx_gap_pct   = pick_idle_pct();
                rx_stall_pct = pick_idle_pct();
                repeat (episode_len) send_item(random_command(fill));
                done += episode_len;
            end
        end
    endtask

    initial begin
        foreach (pm_keys[s]) pm_keys[s] = '0;
        pm_head           = 0;
        pm_count          = 0;
        pm_last_id        = '0;
        pm_ttl            = DEFAULT_TTL;
        cur_tick          = 32'd200;
        last_captured_key = 32'd1;
        tx_gap_pct        = 0;
        rx_stall_pct      = 0;
        rx_hold_request   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_output_backpressure();
        test_ttl_phases();
        wait_results_drained();

        $display("Ran %0d commands over %0d ttl writes: %0d events queued, %0d heads seen,",
                 n_items, n_ttl_writes, n_enqueued, n_live_heads);
        $display("%0d expired on peek, %0d duplicate keys, %0d table-full, %0d ring-full.",
                 n_expired, n_dup_rejects, n_table_full, n_ring_full);
        if (error_count == 0) begin
            $display("dedup_event_queue_with_ttl_unit: match");
        end else begin
            $display("dedup_event_queue_with_ttl_unit: mismatch");
        end
        $finish;
    end

endmodule
